// File: design/mtp_pkg.sv
// ----------------------------------------------------------------------------
// mtp_pkg
// Shared constants, types and word functions of the MT19937 generator.
// ----------------------------------------------------------------------------
package mtp_pkg;

  localparam int STATE_WORDS_DEF = 624;
  localparam int SHIFT_DIST      = 397;
  localparam int IDX_W           = 10;
  localparam int WORD_W          = 32;

  localparam logic [WORD_W-1:0] COEF_A   = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] HIGH_BIT = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] TEMPER_B = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C = 32'hEFC6_0000;

  // Operation codes of a request item
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_GEN  = 1'b1;

  // Kind of work held in the compute stage
  typedef enum logic [1:0] {
    K_GEN,
    K_LOAD,
    K_SWEEP
  } kind_t;

  // Control phase: memory clearing after reset, then normal run
  typedef enum logic {
    PH_CLEAR,
    PH_RUN
  } phase_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
  } rd_req_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [IDX_W-1:0]  step;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] seed;
  } issue_t;

  // One step of the twist recurrence
  function automatic logic [WORD_W-1:0] next_word(input logic [WORD_W-1:0] cur,
                                                  input logic [WORD_W-1:0] nxt,
                                                  input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] r;
    y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    r = far ^ (y >> 1);
    if (y[0]) begin
      r = r ^ COEF_A;
    end
    return r;
  endfunction

  // Output tempering
  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] s;
    s = w;
    s = s ^ (s >> 11);
    s = s ^ ((s << 7) & TEMPER_B);
    s = s ^ ((s << 15) & TEMPER_C);
    s = s ^ (s >> 18);
    return s;
  endfunction

endpackage

// File: design/mtp_ram.sv
// ----------------------------------------------------------------------------
// mtp_ram
// State word memory: one write port, two registered read ports. A read at
// the address being written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module mtp_ram import mtp_pkg::*; #(
  parameter int DEPTH = STATE_WORDS_DEF
) (
  input  logic              clk,
  input  wr_req_t           wr,
  input  rd_req_t           rd,
  output logic [WORD_W-1:0] rd_a,
  output logic [WORD_W-1:0] rd_b
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] a_q;
  logic [WORD_W-1:0] b_q;
  logic [WORD_W-1:0] fwd_data;
  logic              fwd_a;
  logic              fwd_b;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read ports, capture a colliding write for forwarding
  always_ff @(posedge clk) begin
    if (rd.en) begin
      a_q      <= mem[rd.addr_a];
      b_q      <= mem[rd.addr_b];
      fwd_a    <= wr.en && (wr.addr == rd.addr_a);
      fwd_b    <= wr.en && (wr.addr == rd.addr_b);
      fwd_data <= wr.data;
    end
  end

  assign rd_a = fwd_a ? fwd_data : a_q;
  assign rd_b = fwd_b ? fwd_data : b_q;

endmodule

// File: design/mtp_issue.sv
// ----------------------------------------------------------------------------
// mtp_issue
// Request control: memory clearing after reset, twist position tracking,
// item acceptance and read address generation. A load that arrives in the
// middle of a twist round is held until the rest of the round is swept.
// ----------------------------------------------------------------------------
module mtp_issue import mtp_pkg::*; #(
  parameter int STATE_WORDS = STATE_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              operation,
  input  logic [IDX_W-1:0]  word_index,
  input  logic [WORD_W-1:0] seed_word,
  input  logic              s1_free,
  output logic              req_stall,
  output issue_t            iss,
  output rd_req_t           rd,
  output wr_req_t           clr_wr
);

  phase_t           phase;
  phase_t           phase_next;
  logic [IDX_W-1:0] clr_cnt;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] step;
  logic             running;
  logic             round_done;
  logic             accept;
  logic             sweep;
  logic             step_go;

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_CLEAR: begin
        if (clr_cnt == IDX_W'(STATE_WORDS - 1)) begin
          phase_next = PH_RUN;
        end
      end
      PH_RUN: begin
        phase_next = PH_RUN;
      end
      default: phase_next = PH_CLEAR;
    endcase
  end

  // Phase outputs
  always_comb begin
    running     = 1'b0;
    clr_wr.en   = 1'b0;
    clr_wr.addr = clr_cnt;
    clr_wr.data = '0;
    unique case (phase)
      PH_CLEAR: clr_wr.en = 1'b1;
      PH_RUN:   running   = 1'b1;
      default:  running   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_CLEAR;
      clr_cnt <= '0;
    end else begin
      phase <= phase_next;
      if (phase == PH_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Acceptance: a load waits until the current twist round is complete
  assign round_done = (pos == IDX_W'(STATE_WORDS));
  assign accept     = running && s1_free && req_valid &&
                      ((operation == OP_GEN) || round_done);
  assign sweep      = running && s1_free && req_valid &&
                      (operation == OP_LOAD) && !round_done;
  assign step_go    = sweep || (accept && (operation == OP_GEN));
  assign req_stall  = !accept;
  assign step       = round_done ? '0 : pos;

  // Issue one item or one sweep step to the compute stage
  always_comb begin
    iss.valid = accept || sweep;
    iss.step  = step;
    iss.idx   = word_index;
    iss.seed  = seed_word;
    if (sweep) begin
      iss.kind = K_SWEEP;
    end else if (operation == OP_GEN) begin
      iss.kind = K_GEN;
    end else begin
      iss.kind = K_LOAD;
    end
  end

  // Read the following word and the far word of this twist step
  always_comb begin
    rd.en = step_go;
    if (step == IDX_W'(STATE_WORDS - 1)) begin
      rd.addr_a = '0;
    end else begin
      rd.addr_a = step + 1'b1;
    end
    if (step < IDX_W'(STATE_WORDS - SHIFT_DIST)) begin
      rd.addr_b = step + IDX_W'(SHIFT_DIST);
    end else begin
      rd.addr_b = step - IDX_W'(STATE_WORDS - SHIFT_DIST);
    end
  end

  // Advance the twist position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= IDX_W'(STATE_WORDS);
    end else if (step_go) begin
      pos <= step + 1'b1;
    end
  end

  a_no_issue_in_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CLEAR) |-> !iss.valid)
    else $error("item issued during memory clear");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (pos != '0) && (pos <= IDX_W'(STATE_WORDS)))
    else $error("twist position out of range");

  a_sweep_advances: assert property (@(posedge clk) disable iff (rst)
    sweep |=> (pos == $past(pos) + 1'b1))
    else $error("sweep step did not advance position");

endmodule

// File: design/mtp_stage.sv
// ----------------------------------------------------------------------------
// mtp_stage
// Compute stage and result register: twists one state word from the
// carried current word and the two memory reads, writes it back, and
// tempers it for the result. Loads write their seed word here.
// ----------------------------------------------------------------------------
module mtp_stage import mtp_pkg::*; #(
  parameter int STATE_WORDS = STATE_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  issue_t            iss,
  input  logic [WORD_W-1:0] rd_a,
  input  logic [WORD_W-1:0] rd_b,
  input  logic              rsp_stall,
  output logic              s1_free,
  output wr_req_t           wr,
  output logic              rsp_valid,
  output logic [WORD_W-1:0] random_word
);

  logic              s1_valid;
  kind_t             s1_kind;
  logic [IDX_W-1:0]  s1_step;
  logic [IDX_W-1:0]  s1_idx;
  logic [WORD_W-1:0] s1_seed;
  logic [WORD_W-1:0] cur_word;
  logic [WORD_W-1:0] new_word;
  logic              s1_go;
  logic              idx_ok;

  assign s1_go    = s1_valid && ((s1_kind != K_GEN) || !rsp_valid || !rsp_stall);
  assign s1_free  = !s1_valid || s1_go;
  assign new_word = next_word(cur_word, rd_a, rd_b);
  assign idx_ok   = (s1_idx < IDX_W'(STATE_WORDS));

  // Load the stage from the issue side
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= iss.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_kind <= iss.kind;
      s1_step <= iss.step;
      s1_idx  <= iss.idx;
      s1_seed <= iss.seed;
    end
  end

  // Write back a twisted word or a seed word
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = s1_step;
    wr.data = new_word;
    case (s1_kind) inside
      K_GEN, K_SWEEP: begin
        wr.en = s1_go;
      end
      K_LOAD: begin
        wr.en   = s1_go && idx_ok;
        wr.addr = s1_idx;
        wr.data = s1_seed;
      end
      default: wr.en = 1'b0;
    endcase
  end

  // Carry the untwisted word at the next position
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_word <= '0;
    end else if (s1_go) begin
      if (s1_kind != K_LOAD) begin
        cur_word <= rd_a;
      end else if (s1_idx == '0) begin
        cur_word <= s1_seed;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_go && (s1_kind == K_GEN)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_kind == K_GEN)) begin
      random_word <= temper(new_word);
    end
  end

  a_gen_gives_item: assert property (@(posedge clk) disable iff (rst)
    (s1_go && (s1_kind == K_GEN)) |=> rsp_valid)
    else $error("generate step lost its item");

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (wr.addr < IDX_W'(STATE_WORDS)))
    else $error("state write out of range");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_step) && $stable(s1_kind)))
    else $error("stalled stage changed");

endmodule

// File: design/mersenne_twister_prng.sv
// ----------------------------------------------------------------------------
// mersenne_twister_prng
// MT19937 generator with a 624-word state memory and per-word lazy twist.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall): operation selects a load or a
// generate. A load writes seed_word at word_index (an index of 624 or more
// writes nothing) and restarts the twist round. A generate returns one
// tempered word on the result channel (rsp_valid / rsp_stall).
// An accepted generate enters the compute stage register; its tempered word
// is then registered in the result register and held there until taken.
// Throughput: one item per cycle unless stalled. Each generate twists
// exactly one state word: the memory delivers the following and the far
// word on its two read ports while the current word is carried in a
// register from the step before; the new word is written back that cycle.
// A load that arrives partway through a round is stalled while the rest of
// the round is twisted, one word per cycle while the compute stage is free:
// 624 minus the number of words generated since the round began.
// Reset: a clearing pass writes zero into all 624 words, one per cycle, and
// no item is accepted until the pass is over.
// Stall: while rsp_stall holds the result, loads still pass and one more
// generate is taken into the compute stage; after that req_stall rises
// until the result is taken.
// ----------------------------------------------------------------------------
module mersenne_twister_prng import mtp_pkg::*; #(
  parameter int STATE_WORDS = STATE_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic              operation,
  input  logic [IDX_W-1:0]  word_index,
  input  logic [WORD_W-1:0] seed_word,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [WORD_W-1:0] random_word
);

  issue_t            iss;
  rd_req_t           rd;
  wr_req_t           clr_wr;
  wr_req_t           stg_wr;
  wr_req_t           ram_wr;
  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;
  logic              s1_free;

  mtp_issue #(
    .STATE_WORDS(STATE_WORDS)
  ) u_issue (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .operation  (operation),
    .word_index (word_index),
    .seed_word  (seed_word),
    .s1_free    (s1_free),
    .req_stall  (req_stall),
    .iss        (iss),
    .rd         (rd),
    .clr_wr     (clr_wr)
  );

  // Clearing pass owns the write port until it ends
  assign ram_wr = clr_wr.en ? clr_wr : stg_wr;

  mtp_ram #(
    .DEPTH(STATE_WORDS)
  ) u_ram (
    .clk  (clk),
    .wr   (ram_wr),
    .rd   (rd),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  mtp_stage #(
    .STATE_WORDS(STATE_WORDS)
  ) u_stage (
    .clk         (clk),
    .rst         (rst),
    .iss         (iss),
    .rd_a        (rd_a),
    .rd_b        (rd_b),
    .rsp_stall   (rsp_stall),
    .s1_free     (s1_free),
    .wr          (stg_wr),
    .rsp_valid   (rsp_valid),
    .random_word (random_word)
  );

endmodule

// File: sim/mt_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mt_scoreboard
// Watches both channels of the MT19937 generator, keeps its own copy of the
// 624-word state and read position, and checks every returned word against
// the predicted tempered word, oldest first.
// ----------------------------------------------------------------------------
module mt_scoreboard import mtp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  logic              operation,
  input  logic [IDX_W-1:0]  word_index,
  input  logic [WORD_W-1:0] seed_word,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  logic [WORD_W-1:0] random_word,
  output int                fail_count,
  output int                words_due,
  output int                load_count,
  output int                outside_count,
  output int                gen_count,
  output int                twist_count
);

  logic [WORD_W-1:0] mt_words [STATE_WORDS_DEF];
  int unsigned       read_pos;
  logic [WORD_W-1:0] expected_words [$];
  int                fails   = 0;
  int                loads   = 0;
  int                outside = 0;
  int                gens    = 0;
  int                twists  = 0;

  // One step of the twist recurrence
  function automatic logic [WORD_W-1:0] recur_word(input logic [WORD_W-1:0] cur,
                                                   input logic [WORD_W-1:0] nxt,
                                                   input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] joined;
    logic [WORD_W-1:0] res;
    joined = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    res = far ^ (joined >> 1);
    if (joined[0]) begin
      res = res ^ COEF_A;
    end
    return res;
  endfunction

  // Output tempering of one state word
  function automatic logic [WORD_W-1:0] tempered(input logic [WORD_W-1:0] raw);
    logic [WORD_W-1:0] t;
    t = raw;
    t = t ^ (t >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  // Twist the whole state in place, in index order
  task automatic refill_state();
    int k;
    for (k = 0; k < STATE_WORDS_DEF; k++) begin
      mt_words[k] = recur_word(mt_words[k], mt_words[(k + 1) % STATE_WORDS_DEF],
                               mt_words[(k + SHIFT_DIST) % STATE_WORDS_DEF]);
    end
  endtask

  always @(posedge clk) begin : watch
    logic [WORD_W-1:0] want;
    int                k;
    if (rst) begin
      // Drop the model back to its reset state
      for (k = 0; k < STATE_WORDS_DEF; k++) begin
        mt_words[k] = '0;
      end
      read_pos = STATE_WORDS_DEF;
      expected_words.delete();
    end else begin
      // Compare a returned word with the oldest prediction
      if (rsp_valid && !rsp_stall) begin
        if (expected_words.size() == 0) begin
          $error("random_word arrived with no generate item waiting: actual %08h",
                 random_word);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (random_word !== want) begin
            $error("random_word mismatch: expected %08h, actual %08h", want, random_word);
            fails++;
          end
        end
      end
      // Advance the model on an accepted item
      if (req_valid && !req_stall) begin
        if (operation == OP_LOAD) begin
          loads++;
          if (word_index < STATE_WORDS_DEF) begin
            mt_words[word_index] = seed_word;
          end else begin
            outside++;
          end
          read_pos = STATE_WORDS_DEF;
        end else begin
          gens++;
          if (read_pos >= STATE_WORDS_DEF) begin
            refill_state();
            twists++;
            read_pos = 0;
          end
          expected_words.push_back(tempered(mt_words[read_pos]));
          read_pos++;
        end
      end
    end
    fail_count    <= fails;
    words_due     <= expected_words.size();
    load_count    <= loads;
    outside_count <= outside;
    gen_count     <= gens;
    twist_count   <= twists;
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives load and generate items into the MT19937 generator with random
// gaps and result stalls; the scoreboard beside the block checks each word.
// ----------------------------------------------------------------------------
module tb_top import mtp_pkg::*; ();

  localparam int ITEM_TARGET = 1850;
  localparam int IDLE_LIMIT  = 5000;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  logic              operation;
  logic [IDX_W-1:0]  word_index;
  logic [WORD_W-1:0] seed_word;
  logic              rsp_valid;
  logic              rsp_stall;
  logic [WORD_W-1:0] random_word;

  int fail_count;
  int words_due;
  int load_count;
  int outside_count;
  int gen_count;
  int twist_count;

  int items_sent = 0;
  bit steady     = 1'b0;

  mersenne_twister_prng dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .operation   (operation),
    .word_index  (word_index),
    .seed_word   (seed_word),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .random_word (random_word)
  );

  mt_scoreboard chk (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .operation     (operation),
    .word_index    (word_index),
    .seed_word     (seed_word),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .random_word   (random_word),
    .fail_count    (fail_count),
    .words_due     (words_due),
    .load_count    (load_count),
    .outside_count (outside_count),
    .gen_count     (gen_count),
    .twist_count   (twist_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short idle stretches, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Mostly indexes inside the state, some past its end
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(9) == 0) begin
      return IDX_W'($urandom_range(STATE_WORDS_DEF, 1023));
    end
    return IDX_W'($urandom_range(STATE_WORDS_DEF - 1));
  endfunction

  // Present one item and hold it until accepted
  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [WORD_W-1:0] seed);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    operation  <= op;
    word_index <= idx;
    seed_word  <= seed;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
  endtask

  // Result side: random stalls with stall-free stretches
  initial begin : result_side
    int run;
    int hold;
    rsp_stall <= 1'b0;
    forever begin
      run  = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      hold = pick_gap();
      rsp_stall <= 1'b0;
      repeat (run) @(posedge clk);
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int k;
    int n;
    int pick;
    rst        <= 1'b1;
    req_valid  <= 1'b0;
    operation  <= OP_LOAD;
    word_index <= '0;
    seed_word  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Generate from the zero state: every word is zero
    steady = 1'b1;
    repeat (3) send_item(OP_GEN, '0, '0);
    // Loads at the edges of the index and seed ranges, one past the end too
    send_item(OP_LOAD, 10'd0, 32'hFFFF_FFFF);
    send_item(OP_LOAD, 10'd623, 32'h8000_0000);
    send_item(OP_LOAD, 10'd624, 32'h1234_5678);
    send_item(OP_LOAD, 10'd1023, 32'hFFFF_FFFF);
    send_item(OP_LOAD, 10'd397, 32'h0000_0001);
    send_item(OP_LOAD, 10'd1, 32'h7FFF_FFFF);
    steady = 1'b0;
    repeat (4) send_item(OP_GEN, 10'h3FF, 32'hFFFF_FFFF);
    // Load partway through a round, then a load that writes nothing
    send_item(OP_LOAD, 10'd512, 32'hAAAA_AAAA);
    repeat (2) send_item(OP_GEN, '0, '0);
    send_item(OP_LOAD, 10'd1000, 32'h5555_5555);
    repeat (3) send_item(OP_GEN, '0, '0);

    // Full random seed, then run past the end of a round
    for (k = 0; k < STATE_WORDS_DEF; k++) begin
      steady = ($urandom_range(3) == 0);
      send_item(OP_LOAD, IDX_W'(k), $urandom());
    end
    repeat (700) begin
      if ($urandom_range(49) == 0) steady = ~steady;
      send_item(OP_GEN, IDX_W'($urandom_range(1023)), $urandom());
    end

    // Mixed bursts: reseed then generate, noise, plain generate runs
    while (items_sent < ITEM_TARGET) begin
      steady = ($urandom_range(3) == 0);
      pick   = $urandom_range(99);
      if (pick < 70) begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(OP_LOAD, pick_index(), $urandom());
        n = ($urandom_range(19) == 0) ? $urandom_range(625, 700) : $urandom_range(1, 60);
        repeat (n) send_item(OP_GEN, IDX_W'($urandom_range(1023)), $urandom());
      end else if (pick < 90) begin
        n = $urandom_range(1, 10);
        repeat (n) begin
          send_item(($urandom_range(1) == 0) ? OP_LOAD : OP_GEN,
                    IDX_W'($urandom_range(1023)), $urandom());
        end
      end else begin
        n = $urandom_range(1, 30);
        repeat (n) send_item(OP_GEN, IDX_W'($urandom_range(1023)), $urandom());
      end
    end

    // Drain outstanding words
    req_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d items: %0d loads (%0d past the state end), %0d generates",
             items_sent, load_count, outside_count, gen_count);
    $display("The state was twisted as a whole %0d times", twist_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/mtp_pkg.sv
design/mtp_ram.sv
design/mtp_issue.sv
design/mtp_stage.sv
design/mersenne_twister_prng.sv
sim/mt_scoreboard.sv
sim/tb_top.sv
